// ===== hw/rtl/obrf_pkg.sv =====
// Shared types and constants for the overwriting byte ring FIFO.
`default_nettype none

package obrf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned BYTE_W        = 8;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_FLUSH = 2'd3
  } obrf_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } obrf_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/obrf_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module obrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/overwriting_byte_ring_fifo_unit.sv =====
// Top level of the overwriting byte ring FIFO: control, pointers and result register.
//
// Usage
//   Slave stream carries one operation per beat: tuser is the operation
//   (put, get, peek, flush), tdata holds the byte to store and the
//   clear-storage flag. Master stream returns exactly one beat per
//   operation: byte read, fill level after the operation, overwrite flag.
// Timing and throughput
//   Put, flush and a get on an empty ring: result registered in the cycle
//   after the beat is taken, one beat per cycle while the output register
//   is free. A get on stored data and every peek, empty ring or not, go
//   through the RAM's registered read port: no new beat is taken until
//   the result is loaded. A flush with clear set sweeps the RAM, one entry
//   a cycle, and the slave side is held off until the sweep is done.
// Reset
//   Pointers and count clear at once; the storage is then zeroed by the
//   same sweep, with tready low, before the first beat.
// Back-pressure
//   The result sits in an output register; a new beat is taken in the idle
//   state while that register is empty or being drained in the same cycle.
`default_nettype none

module overwriting_byte_ring_fifo_unit #(
  parameter int unsigned DEPTH = obrf_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [7:0] data_in, [8] clear_store, rest zero
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] op
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] data_out, then fill_level, then overwrote_oldest, zero padded
  output logic [((8 + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  import obrf_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned OUTW = ((BYTE_W + CW + 1 + 7) / 8) * 8;

  localparam logic [AW-1:0] PtrLast = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    ptr_next = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  obrf_state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] sweep_q, sweep_d;

  // result register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic [CW-1:0]     out_level_q;
  logic              out_over_q;

  logic              ld_out;
  logic [BYTE_W-1:0] ld_data;
  logic [CW-1:0]     ld_level;
  logic              ld_over;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic     out_free;
  obrf_op_e in_op;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign in_op    = obrf_op_e'(s_axis_tuser_i);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    sweep_d   = sweep_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = rp_q;
    ram_wdata = '0;
    ld_out    = 1'b0;
    ld_data   = '0;
    ld_level  = cnt_q;
    ld_over   = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero one entry per cycle; no beats taken meanwhile
        ram_we   = 1'b1;
        ram_addr = sweep_q;
        if (sweep_q == PtrLast) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = out_free;
        if (s_axis_tvalid_i && out_free) begin
          unique case (in_op)
            OP_PUT: begin
              ram_we    = 1'b1;
              ram_addr  = wp_q;
              ram_wdata = s_axis_tdata_i[BYTE_W-1:0];
              wp_d      = ptr_next(wp_q);
              if (cnt_q == CntFull) begin
                // full: drop the oldest byte
                rp_d    = ptr_next(rp_q);
                ld_over = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
              ld_out   = 1'b1;
              ld_level = cnt_d;
            end
            OP_GET: begin
              if (cnt_q != '0) begin
                ram_re  = 1'b1;
                rp_d    = ptr_next(rp_q);
                cnt_d   = cnt_q - 1'b1;
                state_d = ST_READ;
              end else begin
                ld_out = 1'b1;  // empty: zero byte
              end
            end
            OP_PEEK: begin
              ram_re  = 1'b1;  // may be a stale entry
              state_d = ST_READ;
            end
            OP_FLUSH: begin
              wp_d     = '0;
              rp_d     = '0;
              cnt_d    = '0;
              ld_out   = 1'b1;
              ld_level = '0;
              if (s_axis_tdata_i[BYTE_W]) begin
                sweep_d = '0;
                state_d = ST_CLEAR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // output register is free here: it was free or draining at acceptance
        ld_out   = 1'b1;
        ld_data  = ram_rdata;
        ld_level = cnt_q;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_data_q  <= ld_data;
      out_level_q <= ld_level;
      out_over_q  <= ld_over;
    end
  end

  obrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUTW'({out_over_q, out_level_q, out_data_q});

endmodule

`default_nettype wire
